/* rtl/icf_pkg.sv */
// ----------------------------------------------------------------------------
// icf_pkg: shared types, constants and tables for the inharmonicity fit unit
// Fixed-point coefficients in Q.24, log2/exp2 tables built at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icf_pkg;

  // Table addressing
  localparam int TAB_BITS  = 8;
  localparam int TAB_SIZE  = 1 << TAB_BITS;

  // Number formats
  localparam int QF        = 24;
  localparam int MANT_BITS = 21;
  localparam int F_W       = 22;
  localparam int B_W       = 27;
  localparam int PW        = $clog2(F_W);
  localparam int IN_FRAC   = 8;
  localparam int REF_HZ    = 440;

  localparam int LOG_SHIFT  = MANT_BITS - TAB_BITS;
  localparam int LOG_ENT_W  = QF + 1;
  localparam int LOG_PROD_W = LOG_ENT_W + LOG_SHIFT;

  localparam int EXP_SHIFT  = QF - TAB_BITS;
  localparam int EXP_ENT_W  = 32;
  localparam int EXP_PROD_W = EXP_ENT_W + EXP_SHIFT;
  localparam int EXP_FRAC   = 30;
  localparam int EXP_N_MAX  = 29;
  localparam int EXP_BIAS   = 32;
  localparam int VAL_W      = EXP_ENT_W + 1;
  localparam int SH_W       = 5;

  localparam int X_W   = 32;
  localparam int SQ_W  = 36;
  localparam int SUM_W = 40;
  localparam int Y_W   = 32;
  localparam int W_W   = 40;
  localparam int P_W   = 64;

  // Q.24 coefficients
  localparam logic signed [X_W-1:0] C0_Q    = -32'sd110328237;
  localparam logic signed [X_W-1:0] C1_Q    =  32'sd32107787;
  localparam logic signed [X_W-1:0] C2_Q    =  32'sd4632988;
  localparam logic signed [X_W-1:0] C3_Q    = -32'sd4793710;
  localparam logic signed [X_W-1:0] C4_Q    = -32'sd5152224;
  localparam logic signed [X_W-1:0] KNOT_Q  =  32'sd22369621;
  localparam logic signed [X_W-1:0] LN_LO_Q = -32'sd204783917;
  localparam logic signed [X_W-1:0] LN_HI_Q = -32'sd65632855;
  localparam logic signed [X_W-1:0] LOG2E_Q =  32'sd24204406;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_e;

  typedef logic [LOG_ENT_W-1:0] log_ent_t;
  typedef logic [EXP_ENT_W-1:0] exp_ent_t;
  typedef log_ent_t log_tab_t [0:TAB_SIZE];
  typedef exp_ent_t exp_tab_t [0:TAB_SIZE];

  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic signed [X_W-1:0] x;
  } log2_res_t;

  typedef struct packed {
    logic                  valid;
    clamp_e                state;
    logic signed [Y_W-1:0] y;
  } lnb_t;

  typedef struct packed {
    logic           valid;
    clamp_e         state;
    logic [B_W-1:0] coef;
  } coef_t;

  // Round a Q.48 product to Q.24, ties away from zero
  function automatic logic signed [P_W-1:0] rnd_q(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] half;
    logic signed [P_W-1:0] adj;
    logic signed [P_W-1:0] tmp;
    half = 64'sd1 <<< (QF - 1);
    adj  = v[P_W-1] ? 64'sd1 : 64'sd0;
    tmp  = v + half - adj;
    return tmp >>> QF;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > n) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i/2^TAB_BITS) by repeated squaring, truncated per bit
  function automatic log_ent_t log_entry(input logic [63:0] i);
    logic [63:0] v;
    log_ent_t    res;
    res = '0;
    if (i >= 64'(TAB_SIZE)) return LOG_ENT_W'(1) << QF;
    v = (64'd1 << 30) + (i << (30 - TAB_BITS));
    for (int k = 0; k < QF; k++) begin
      v   = (v * v) >> 30;
      res = res << 1;
      if (v >= (64'd1 << 31)) begin
        res[0] = 1'b1;
        v      = v >> 1;
      end
    end
    return res;
  endfunction

  // 2^(i/2^TAB_BITS) in Q1.30 from chained square roots of two
  function automatic exp_ent_t exp_entry(input logic [63:0] i);
    logic [63:0] acc;
    logic [63:0] root;
    acc  = 64'd1 << 30;
    root = isqrt64(64'd2 << 60);
    if (i >= 64'(TAB_SIZE)) return EXP_ENT_W'(64'd1 << 31);
    for (int m = 0; m < TAB_BITS; m++) begin
      if (i[TAB_BITS-1-m]) acc = (acc * root) >> 30;
      root = isqrt64(root << 30);
    end
    return EXP_ENT_W'(acc);
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int i = 0; i <= TAB_SIZE; i++) t[i] = log_entry(64'(i));
    return t;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    for (int i = 0; i <= TAB_SIZE; i++) t[i] = exp_entry(64'(i));
    return t;
  endfunction

  // Interpolated log2 of a nonzero Q14.8 constant, in Q.24
  function automatic logic signed [63:0] const_log2_q(input logic [63:0] f);
    int              p;
    logic [63:0]     frac;
    logic [63:0]     idx;
    logic [63:0]     rem;
    logic [63:0]     t0;
    logic [63:0]     t1;
    logic signed [63:0] r;
    p = 0;
    for (int k = 0; k < F_W; k++) if (f[k]) p = k;
    frac = (f << (MANT_BITS - p)) & ((64'd1 << MANT_BITS) - 64'd1);
    idx  = frac >> LOG_SHIFT;
    rem  = frac & ((64'd1 << LOG_SHIFT) - 64'd1);
    t0   = 64'(log_entry(idx));
    t1   = 64'(log_entry(idx + 64'd1));
    if (t1 < t0) t1 = t0;
    t0 = t0 + (((t1 - t0) * rem + (64'd1 << (LOG_SHIFT - 1))) >> LOG_SHIFT);
    r  = 64'(p - IN_FRAC);
    r  = (r <<< QF) + t0;
    return r;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

  localparam logic signed [X_W-1:0] LOG_REF_Q =
    X_W'(const_log2_q(64'(REF_HZ) << IN_FRAC));

endpackage

/* rtl/icf_log2.sv */
// ----------------------------------------------------------------------------
// icf_log2: four-stage log2 of the fundamental, relative to 440 Hz
// Leading-one normalize, table lookup, interpolation product, final sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icf_log2 import icf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [F_W-1:0] freq_i,
  output log2_res_t      res_o
);

  logic [3:0] vld_q;

  // Stage 1: normalize
  logic [PW-1:0]              msb_d;
  logic [F_W+MANT_BITS-1:0]   norm;
  logic [MANT_BITS-1:0]       frac;
  logic [PW-1:0]              msb1_q;
  logic [TAB_BITS-1:0]        idx1_q;
  logic [LOG_SHIFT-1:0]       rem1_q;
  logic                       zero1_q;

  always_comb begin
    msb_d = '0;
    for (int k = 0; k < F_W; k++) begin
      if (freq_i[k]) msb_d = PW'(k);
    end
    norm = {{MANT_BITS{1'b0}}, freq_i} << (PW'(MANT_BITS) - msb_d);
    frac = norm[MANT_BITS-1:0];
  end

  // Stage 2: table lookup
  logic [TAB_BITS:0]    idx_lo;
  logic [TAB_BITS:0]    idx_hi;
  log_ent_t             t0_d;
  log_ent_t             t1_d;
  log_ent_t             t0_2_q;
  log_ent_t             diff2_q;
  logic [LOG_SHIFT-1:0] rem2_q;
  logic [PW-1:0]        msb2_q;
  logic                 zero2_q;

  always_comb begin
    idx_lo = {1'b0, idx1_q};
    idx_hi = idx_lo + 1'b1;
    t0_d   = LOG_TAB[idx_lo];
    t1_d   = LOG_TAB[idx_hi];
  end

  // Stage 3: interpolation product and integer part
  logic [LOG_PROD_W-1:0]  prod3_q;
  logic signed [X_W-1:0]  pint;
  logic signed [X_W-1:0]  base_d;
  logic signed [X_W-1:0]  base3_q;
  log_ent_t               t0_3_q;
  logic                   zero3_q;

  always_comb begin
    pint   = X_W'(msb2_q) - X_W'(IN_FRAC);
    base_d = (pint <<< QF) - LOG_REF_Q;
  end

  // Stage 4: round interpolation and sum
  logic [LOG_PROD_W:0]   interp_sum;
  log_ent_t              interp;
  logic signed [X_W-1:0] x_d;
  logic signed [X_W-1:0] x4_q;
  logic                  zero4_q;

  always_comb begin
    interp_sum = {1'b0, prod3_q} + (LOG_PROD_W+1)'(1 << (LOG_SHIFT - 1));
    interp     = LOG_ENT_W'(interp_sum >> LOG_SHIFT);
    x_d        = base3_q + X_W'(t0_3_q) + X_W'(interp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    msb1_q  <= msb_d;
    idx1_q  <= frac[MANT_BITS-1 -: TAB_BITS];
    rem1_q  <= frac[LOG_SHIFT-1:0];
    zero1_q <= (freq_i == '0);

    t0_2_q  <= t0_d;
    diff2_q <= (t1_d >= t0_d) ? (t1_d - t0_d) : '0;
    rem2_q  <= rem1_q;
    msb2_q  <= msb1_q;
    zero2_q <= zero1_q;

    prod3_q <= LOG_PROD_W'(diff2_q) * LOG_PROD_W'(rem2_q);
    base3_q <= base_d;
    t0_3_q  <= t0_2_q;
    zero3_q <= zero2_q;

    x4_q    <= x_d;
    zero4_q <= zero3_q;
  end

  assign res_o.valid = vld_q[3];
  assign res_o.zero  = zero4_q;
  assign res_o.x     = x4_q;

endmodule

/* rtl/icf_poly.sv */
// ----------------------------------------------------------------------------
// icf_poly: hinged quadratic for ln B and the clamp to its limits
// Seven stages: knots, squares, rounding, weights, rounding, sum, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icf_poly import icf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  log2_res_t req_i,
  output lnb_t      res_o
);

  logic [6:0] vld_q;

  // Stage 1: hinge offsets
  logic signed [X_W-1:0] h1_d;
  logic signed [X_W-1:0] h2_d;
  logic signed [X_W-1:0] x1_q;
  logic signed [X_W-1:0] h1_q;
  logic signed [X_W-1:0] h2_q;
  logic                  pos1_q;
  logic                  pos2_q;
  logic                  zero1_q;

  assign h1_d = req_i.x + KNOT_Q;
  assign h2_d = req_i.x - KNOT_Q;

  // Stage 2: raw squares and linear term
  logic signed [P_W-1:0] pxx_q;
  logic signed [P_W-1:0] ph1_q;
  logic signed [P_W-1:0] ph2_q;
  logic signed [P_W-1:0] pc1_q;
  logic                  pos1_2_q;
  logic                  pos2_2_q;
  logic                  zero2_q;

  // Stage 3: rounded squares
  logic signed [SQ_W-1:0]  sxx_q;
  logic signed [SQ_W-1:0]  sh1_q;
  logic signed [SQ_W-1:0]  sh2_q;
  logic signed [SUM_W-1:0] c1x3_q;
  logic                    pos1_3_q;
  logic                    pos2_3_q;
  logic                    zero3_q;

  // Stage 4: weighted squares
  logic signed [P_W-1:0]   q2_q;
  logic signed [P_W-1:0]   q3_q;
  logic signed [P_W-1:0]   q4_q;
  logic signed [SUM_W-1:0] c1x4_q;
  logic                    pos1_4_q;
  logic                    pos2_4_q;
  logic                    zero4_q;

  // Stage 5: rounded terms, hinges gated
  logic signed [SUM_W-1:0] t2_q;
  logic signed [SUM_W-1:0] t3_q;
  logic signed [SUM_W-1:0] t4_q;
  logic signed [SUM_W-1:0] c1x5_q;
  logic                    zero5_q;

  // Stage 6: sum
  logic signed [SUM_W-1:0] y6_q;
  logic                    zero6_q;

  // Stage 7: clamp
  logic signed [Y_W-1:0] y_d;
  clamp_e                st_d;
  logic signed [Y_W-1:0] y7_q;
  clamp_e                st7_q;

  always_comb begin
    priority if (zero6_q) begin
      y_d  = LN_HI_Q;
      st_d = CLAMP_HIGH;
    end else if (y6_q < SUM_W'(LN_LO_Q)) begin
      y_d  = LN_LO_Q;
      st_d = CLAMP_LOW;
    end else if (y6_q > SUM_W'(LN_HI_Q)) begin
      y_d  = LN_HI_Q;
      st_d = CLAMP_HIGH;
    end else begin
      y_d  = Y_W'(y6_q);
      st_d = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q     <= req_i.x;
    h1_q     <= h1_d;
    h2_q     <= h2_d;
    pos1_q   <= ~h1_d[X_W-1] & (|h1_d);
    pos2_q   <= ~h2_d[X_W-1] & (|h2_d);
    zero1_q  <= req_i.zero;

    pxx_q    <= x1_q * x1_q;
    ph1_q    <= h1_q * h1_q;
    ph2_q    <= h2_q * h2_q;
    pc1_q    <= C1_Q * x1_q;
    pos1_2_q <= pos1_q;
    pos2_2_q <= pos2_q;
    zero2_q  <= zero1_q;

    sxx_q    <= SQ_W'(rnd_q(pxx_q));
    sh1_q    <= SQ_W'(rnd_q(ph1_q));
    sh2_q    <= SQ_W'(rnd_q(ph2_q));
    c1x3_q   <= SUM_W'(rnd_q(pc1_q));
    pos1_3_q <= pos1_2_q;
    pos2_3_q <= pos2_2_q;
    zero3_q  <= zero2_q;

    q2_q     <= C2_Q * sxx_q;
    q3_q     <= C3_Q * sh1_q;
    q4_q     <= C4_Q * sh2_q;
    c1x4_q   <= c1x3_q;
    pos1_4_q <= pos1_3_q;
    pos2_4_q <= pos2_3_q;
    zero4_q  <= zero3_q;

    t2_q     <= SUM_W'(rnd_q(q2_q));
    t3_q     <= pos1_4_q ? SUM_W'(rnd_q(q3_q)) : '0;
    t4_q     <= pos2_4_q ? SUM_W'(rnd_q(q4_q)) : '0;
    c1x5_q   <= c1x4_q;
    zero5_q  <= zero4_q;

    y6_q     <= SUM_W'(C0_Q) + c1x5_q + t2_q + t3_q + t4_q;
    zero6_q  <= zero5_q;

    y7_q     <= y_d;
    st7_q    <= st_d;
  end

  assign res_o.valid = vld_q[6];
  assign res_o.state = st7_q;
  assign res_o.y     = y7_q;

endmodule

/* rtl/icf_exp2.sv */
// ----------------------------------------------------------------------------
// icf_exp2: base-2 exponent of ln B, scaled to Q0.32
// Five stages: log2(e) product, bias/round, lookup, interpolation, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icf_exp2 import icf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  lnb_t  req_i,
  output coef_t res_o
);

  logic [4:0] vld_q;

  // Stage 1: z product
  logic signed [P_W-1:0] pz_q;
  clamp_e                st1_q;

  // Stage 2: round z and add the exponent bias
  logic signed [P_W-1:0] half;
  logic signed [P_W-1:0] bias;
  logic signed [P_W-1:0] adj;
  logic signed [P_W-1:0] wsum;
  logic signed [W_W-1:0] w2_q;
  clamp_e                st2_q;

  always_comb begin
    half = 64'sd1 <<< (QF - 1);
    bias = 64'(EXP_BIAS) <<< (2 * QF);
    adj  = pz_q[P_W-1] ? 64'sd1 : 64'sd0;
    wsum = pz_q + half + bias - adj;
  end

  // Stage 3: table lookup and shift count
  logic [QF-1:0]        fr;
  logic [TAB_BITS:0]    idx_lo;
  logic [TAB_BITS:0]    idx_hi;
  exp_ent_t             e0_d;
  exp_ent_t             e1_d;
  logic [SH_W-1:0]      n_d;
  exp_ent_t             e0_3_q;
  exp_ent_t             diff3_q;
  logic [EXP_SHIFT-1:0] rem3_q;
  logic [SH_W-1:0]      sh3_q;
  clamp_e               st3_q;

  always_comb begin
    fr     = w2_q[QF-1:0];
    idx_lo = {1'b0, fr[QF-1 -: TAB_BITS]};
    idx_hi = idx_lo + 1'b1;
    e0_d   = EXP_TAB[idx_lo];
    e1_d   = EXP_TAB[idx_hi];
    priority if (w2_q[W_W-1]) begin
      n_d = '0;
    end else if (w2_q[W_W-1:QF] > (W_W-QF)'(EXP_N_MAX)) begin
      n_d = SH_W'(EXP_N_MAX);
    end else begin
      n_d = w2_q[QF +: SH_W];
    end
  end

  // Stage 4: interpolation product
  logic [EXP_PROD_W-1:0] prod4_q;
  exp_ent_t              e0_4_q;
  logic [SH_W-1:0]       sh4_q;
  clamp_e                st4_q;

  // Stage 5: interpolated mantissa
  logic [EXP_PROD_W:0] interp_sum;
  logic [VAL_W-1:0]    val_d;
  logic [VAL_W-1:0]    val5_q;
  logic [SH_W-1:0]     sh5_q;
  clamp_e              st5_q;

  always_comb begin
    interp_sum = {1'b0, prod4_q} + (EXP_PROD_W+1)'(1 << (EXP_SHIFT - 1));
    val_d      = {1'b0, e0_4_q} + VAL_W'(interp_sum >> EXP_SHIFT);
  end

  // Scale down with round half up
  logic [VAL_W:0] one_sh;
  logic [VAL_W:0] bsum;
  logic [VAL_W:0] bval;

  always_comb begin
    one_sh = (VAL_W+1)'(1) << (sh5_q - 1'b1);
    bsum   = {1'b0, val5_q} + one_sh;
    bval   = bsum >> sh5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pz_q    <= req_i.y * LOG2E_Q;
    st1_q   <= req_i.state;

    w2_q    <= W_W'(wsum >>> QF);
    st2_q   <= st1_q;

    e0_3_q  <= e0_d;
    diff3_q <= (e1_d >= e0_d) ? (e1_d - e0_d) : '0;
    rem3_q  <= fr[EXP_SHIFT-1:0];
    sh3_q   <= SH_W'(EXP_FRAC) - n_d;
    st3_q   <= st2_q;

    prod4_q <= EXP_PROD_W'(diff3_q) * EXP_PROD_W'(rem3_q);
    e0_4_q  <= e0_3_q;
    sh4_q   <= sh3_q;
    st4_q   <= st3_q;

    val5_q  <= val_d;
    sh5_q   <= sh4_q;
    st5_q   <= st4_q;
  end

  assign res_o.valid = vld_q[4];
  assign res_o.state = st5_q;
  assign res_o.coef  = bval[B_W-1:0];

endmodule

/* rtl/inharmonicity_coefficient_fit_unit.sv */
// ----------------------------------------------------------------------------
// done_o follows the input register, log2, poly and exp2 stages and done_q.
// Throughput: one request per cycle; busy_o is never raised, since the
// fixed-length pipeline (log2, polynomial, exp2 stages) never stalls.
// Reset clears the valid bits of every stage; data registers keep no reset.
// ----------------------------------------------------------------------------
// inharmonicity_coefficient_fit_unit: piano string B from the fundamental
// Input and output registers around the log2, polynomial and exp2 pipelines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inharmonicity_coefficient_fit_unit import icf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [F_W-1:0] fundamental_hz_i,
  output logic           done_o,
  output logic [B_W-1:0] coefficient_b_o,
  output logic [1:0]     clamp_state_o
);

  logic           in_vld_q;
  logic [F_W-1:0] freq_q;
  log2_res_t      log_res;
  lnb_t           lnb_res;
  coef_t          coef_res;
  logic           done_q;
  logic [B_W-1:0] coef_q;
  clamp_e         clamp_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
      done_q   <= coef_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q  <= fundamental_hz_i;
    coef_q  <= coef_res.coef;
    clamp_q <= coef_res.state;
  end

  icf_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .freq_i  (freq_q),
    .res_o   (log_res)
  );

  icf_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_res),
    .res_o  (lnb_res)
  );

  icf_exp2 u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lnb_res),
    .res_o  (coef_res)
  );

  assign done_o          = done_q;
  assign coefficient_b_o = coef_q;
  assign clamp_state_o   = clamp_q;

endmodule
